>>> rtl/core/text_cell_framebuffer_ansi_unit_macros.svh
// Assertion helpers for the cell framebuffer.
`ifndef TEXT_CELL_FRAMEBUFFER_ANSI_UNIT_MACROS_SVH
`define TEXT_CELL_FRAMEBUFFER_ANSI_UNIT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define TCFB_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TCFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tcfb_pkg.sv
`timescale 1ns / 1ps
package tcfb_pkg;

	localparam int MAX_ROWS_DEF = 32;
	localparam int MAX_COLS_DEF = 128;

	localparam logic [5:0] ROWS_RST  = 6'd24;
	localparam logic [7:0] COLS_RST  = 8'd80;
	localparam logic       COLOR_RST = 1'b1;

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_POINT  = 3'd1;
	localparam logic [2:0] OP_HLINE  = 3'd2;
	localparam logic [2:0] OP_VLINE  = 3'd3;
	localparam logic [2:0] OP_RECT   = 3'd4;
	localparam logic [2:0] OP_RENDER = 3'd5;

	localparam logic [1:0] REG_ROWS  = 2'd0;
	localparam logic [1:0] REG_COLS  = 2'd1;
	localparam logic [1:0] REG_COLOR = 2'd2;

	typedef struct packed {
		logic [7:0] ch;
		logic [4:0] fg;
		logic [4:0] bg;
	} cell_t;

	localparam cell_t CELL_BLANK = '{ch: 8'h20, fg: 5'd0, bg: 5'd0};

	typedef struct packed {
		logic  load;
		cell_t entry;
		logic  color;
		logic  newline;
	} emit_load_t;

endpackage

>>> rtl/core/tcfb_ram.sv
`timescale 1ns / 1ps
module tcfb_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 4096
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/core/tcfb_emit.sv
`timescale 1ns / 1ps
module tcfb_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcfb_pkg::emit_load_t ld,
	output logic                 active,
	output logic                 result_valid,
	output logic [7:0]           out_byte,
	output logic                 last_byte
);
	import tcfb_pkg::*;

	localparam int SLOTS = 18;

	logic [SLOTS-1:0] mask_q;
	logic [SLOTS-1:0] mask_d;
	logic [SLOTS-1:0] pick;
	cell_t            cell_q;
	logic [7:0]       fg_dig;
	logic [7:0]       bg_dig;
	logic [7:0]       slot [SLOTS];
	logic             col, fe, be, big;

	always_comb begin
		col = ld.color;
		fe  = ld.entry.fg != 5'd0;
		be  = ld.entry.bg != 5'd0;
		big = ld.entry.fg > 5'd8;
		mask_d = {ld.newline, {5{col}}, 1'b1, col, {2{col & be}},
			{3{col & fe}}, {2{col & big}}, {3{col}}};
	end

	always_comb begin
		fg_dig = 8'h30 + {5'd0, 3'(cell_q.fg - 5'd1)};
		bg_dig = 8'h30 + {5'd0, 3'(cell_q.bg - 5'd1)};
		slot[0]  = 8'h1b;
		slot[1]  = 8'h5b;
		slot[2]  = 8'h30;
		slot[3]  = 8'h31;
		slot[4]  = 8'h3b;
		slot[5]  = 8'h33;
		slot[6]  = fg_dig;
		slot[7]  = 8'h3b;
		slot[8]  = 8'h34;
		slot[9]  = bg_dig;
		slot[10] = 8'h6d;
		slot[11] = cell_q.ch;
		slot[12] = 8'h1b;
		slot[13] = 8'h5b;
		slot[14] = 8'h30;
		slot[15] = 8'h3b;
		slot[16] = 8'h6d;
		slot[17] = 8'h0a;
	end

	always_comb begin
		pick = mask_q & (~mask_q + SLOTS'(1));
		out_byte = 8'd0;
		for (int k = 0; k < SLOTS; k++) begin
			out_byte = out_byte | (pick[k] ? slot[k] : 8'd0);
		end
	end

	assign result_valid = |mask_q;
	assign active       = |mask_q;
	assign last_byte    = result_valid && ((mask_q & (mask_q - SLOTS'(1))) == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (ld.load) begin
			mask_q <= mask_d;
		end else begin
			mask_q <= mask_q & ~pick;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.load) begin
			cell_q <= ld.entry;
		end
	end
endmodule

>>> rtl/core/text_cell_framebuffer_ansi_unit.sv
// Draw: one cell per cycle over the clipped area, then ST_DRAIN; the memory's
//   read-modify-write pipeline paces the walk.
// Render of a visible cell: read it, then 1 to 18 result beats at one per cycle.
// Clear: one cell per cycle over all MAX_ROWS*MAX_COLS cells (4096 at defaults).
// Reset: registers return to 24 rows, 80 columns, color on, then the same
//   clearing pass runs with busy high. Results cannot be stalled.
`timescale 1ns / 1ps
module text_cell_framebuffer_ansi_unit #(
	parameter int MAX_ROWS = tcfb_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = tcfb_pkg::MAX_COLS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        operation,
	input  logic signed [9:0] row_a,
	input  logic signed [9:0] col_a,
	input  logic signed [9:0] row_b,
	input  logic signed [9:0] col_b,
	input  logic [7:0]        character,
	input  logic [4:0]        fore_color,
	input  logic [4:0]        back_color,
	input  logic [4:0]        frame_color,
	output logic              result_valid,
	output logic [7:0]        out_byte,
	output logic              last_byte,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data
);
	import tcfb_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int RW = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
	localparam int CW = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_WALK, ST_DRAIN, ST_RREAD, ST_RLOAD
	} state_t;

	state_t state_q;

	logic [5:0] rows_q;
	logic [7:0] cols_q;
	logic       color_q;

	logic [AW-1:0] clr_q;
	logic [RW-1:0] row_q, r1_q;
	logic [CW-1:0] col_q, c0_q, c1_q;
	logic signed [10:0] ra_q, rb_q, ca_q, cb_q;
	logic       rect_q, nl_q;
	logic [7:0] ch_q;
	logic [4:0] fg_q, bg_q, bb_q;

	logic          wr_s1, border_s1;
	logic [AW-1:0] addr_s1;

	logic signed [10:0] vr, vc, ra, rb, ca, cb;
	logic signed [10:0] rlo, rhi, clo, chi, r0, r1, c0, c1;
	logic               nonempty, vis;
	logic [4:0]         fg_in, bg_in, bc_in;
	logic               accept, walk_last, border, do_wr;
	logic [AW-1:0]      raddr, waddr;
	cell_t              rdata, wdata, upd;
	logic               we;
	logic               emit_active;
	emit_load_t         ld;

	function automatic logic [4:0] clamp_color(input logic [4:0] c);
		return (c > 5'd16) ? 5'd16 : c;
	endfunction

	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	always_comb begin
		vr = ({5'd0, rows_q} > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : 11'({5'd0, rows_q});
		vc = ({1'b0, cols_q} > 9'(MAX_COLS)) ? 11'(MAX_COLS) : 11'({3'd0, cols_q});
		ra = 11'(row_a);
		rb = 11'(row_b);
		ca = 11'(col_a);
		cb = 11'(col_b);
		rlo = ra;
		rhi = ra;
		clo = ca;
		chi = ca;
		unique case (operation)
			OP_HLINE: begin
				clo = (ca < cb) ? ca : cb;
				chi = (ca < cb) ? cb : ca;
			end
			OP_VLINE: begin
				rlo = (ra < rb) ? ra : rb;
				rhi = (ra < rb) ? rb : ra;
			end
			OP_RECT: begin
				rhi = rb;
				chi = cb;
			end
			default: begin
			end
		endcase
		r0 = (rlo < 11'sd0) ? 11'sd0 : rlo;
		c0 = (clo < 11'sd0) ? 11'sd0 : clo;
		r1 = (rhi < vr - 11'sd1) ? rhi : vr - 11'sd1;
		c1 = (chi < vc - 11'sd1) ? chi : vc - 11'sd1;
		nonempty = (r0 <= r1) && (c0 <= c1);
		vis = (ra >= 11'sd0) && (ca >= 11'sd0) && (ra < vr) && (ca < vc);
		fg_in = clamp_color(fore_color);
		bg_in = clamp_color(back_color);
		bc_in = clamp_color(frame_color);
	end

	always_comb begin
		raddr = AW'(AW'(row_q) * AW'(MAX_COLS) + AW'(col_q));
		walk_last = (row_q == r1_q) && (col_q == c1_q);
		border = !rect_q || (11'(row_q) == ra_q) || (11'(row_q) == rb_q) ||
			(11'(col_q) == ca_q) || (11'(col_q) == cb_q);
		do_wr = border || (bg_q != 5'd0);
	end

	always_comb begin
		upd = rdata;
		if (border_s1) begin
			upd.ch = ch_q;
			if (fg_q != 5'd0) upd.fg = fg_q;
			if (bb_q != 5'd0) upd.bg = bb_q;
		end else begin
			upd.ch = 8'h20;
			upd.bg = bg_q;
		end
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = CELL_BLANK;
		end else begin
			we    = wr_s1;
			waddr = addr_s1;
			wdata = upd;
		end
		ld.load    = state_q == ST_RLOAD;
		ld.entry   = rdata;
		ld.color   = color_q;
		ld.newline = nl_q;
	end

	assign busy = (state_q != ST_IDLE) || emit_active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= ROWS_RST;
			cols_q  <= COLS_RST;
			color_q <= COLOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROWS:  rows_q  <= cfg_data[5:0];
				REG_COLS:  cols_q  <= cfg_data;
				REG_COLOR: color_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			wr_s1   <= 1'b0;
		end else begin
			wr_s1 <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (operation)
							OP_CLEAR: begin
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							OP_POINT, OP_HLINE, OP_VLINE, OP_RECT: begin
								if (nonempty) state_q <= ST_WALK;
							end
							OP_RENDER: begin
								if (vis) state_q <= ST_RREAD;
							end
							default: begin
							end
						endcase
					end
				end
				ST_WALK: begin
					wr_s1 <= do_wr;
					if (walk_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN: state_q <= ST_IDLE;
				ST_RREAD: state_q <= ST_RLOAD;
				ST_RLOAD: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			if (operation == OP_RENDER) begin
				row_q <= RW'(ra);
				col_q <= CW'(ca);
			end else begin
				row_q <= RW'(r0);
				col_q <= CW'(c0);
			end
			r1_q   <= RW'(r1);
			c0_q   <= CW'(c0);
			c1_q   <= CW'(c1);
			ra_q   <= ra;
			rb_q   <= rb;
			ca_q   <= ca;
			cb_q   <= cb;
			rect_q <= operation == OP_RECT;
			nl_q   <= ca == vc - 11'sd1;
			ch_q   <= character;
			fg_q   <= fg_in;
			bg_q   <= bg_in;
			bb_q   <= (operation == OP_RECT) ? bc_in : bg_in;
		end else if (state_q == ST_WALK) begin
			if (col_q == c1_q) begin
				col_q <= c0_q;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
		addr_s1   <= raddr;
		border_s1 <= border;
	end

	tcfb_ram #(.WIDTH($bits(cell_t)), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	tcfb_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.ld           (ld),
		.active       (emit_active),
		.result_valid (result_valid),
		.out_byte     (out_byte),
		.last_byte    (last_byte)
	);
endmodule

>>> rtl/core/tcfb_checker.sv
`timescale 1ns / 1ps
`include "text_cell_framebuffer_ansi_unit_macros.svh"
module tcfb_checker (
	input logic clk,
	input logic arst_n,
	input logic busy,
	input logic result_valid,
	input logic last_byte
);
	`TCFB_ASSERT_SAME(a_beat_busy, clk, arst_n, result_valid, busy, "beat while idle")
	`TCFB_ASSERT_NEXT(a_last_ends, clk, arst_n, result_valid && last_byte, !result_valid, "beat after last")
	`TCFB_ASSERT_SAME(a_last_valid, clk, arst_n, last_byte, result_valid, "last without beat")
	`TCFB_ASSERT_NEXT(a_beat_cont, clk, arst_n, result_valid && !last_byte, result_valid, "gap in render")
endmodule

bind text_cell_framebuffer_ansi_unit tcfb_checker u_tcfb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.busy         (busy),
	.result_valid (result_valid),
	.last_byte    (last_byte)
);
